// ===== src/s2l_pkg.sv =====
// ----------------------------------------------------------------------------
// s2l_pkg: shared types and constants for the solar to lunar date converter
// Holds the payload structs, the sequencer states, the lunar year table and
// the small calendar helpers.
// ----------------------------------------------------------------------------
package s2l_pkg;

    // calendar range and fixed widths
    localparam int BASE_YEAR      = 1900;
    localparam int LAST_YEAR_MAX  = 2100;
    localparam int YEAR_ROM_WORDS = LAST_YEAR_MAX - BASE_YEAR + 1;
    localparam int WORD_W         = 17;
    localparam int DAYS_W         = 17;
    localparam int YLEN_W         = 9;
    localparam int MLEN_W         = 5;
    localparam int MONTHS         = 12;
    localparam int BASE_DAY       = 31;
    localparam int MONTH_BASE     = 29;
    localparam int YEAR_BASE_LEN  = MONTHS * MONTH_BASE;
    localparam int STEM_COUNT     = 10;
    localparam int BRANCH_COUNT   = 12;
    localparam int STEM_START     = (BASE_YEAR - 4) % STEM_COUNT;
    localparam int BRANCH_START   = (BASE_YEAR - 4) % BRANCH_COUNT;
    localparam int C100_START     = BASE_YEAR % 100;
    localparam int C400_START     = BASE_YEAR % 400;

    // input transaction
    typedef struct packed {
        logic [11:0] solar_year;
        logic [3:0]  solar_month;
        logic [4:0]  solar_day;
    } s2l_in_t;

    // result transaction
    typedef struct packed {
        logic        valid_res;
        logic [11:0] lunar_year;
        logic [3:0]  lun_month;
        logic [4:0]  lun_day;
        logic        in_leap_month;
        logic [3:0]  stem_index;
        logic [3:0]  branch_index;
    } s2l_out_t;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GYEAR,
        ST_YPRIME,
        ST_YWALK,
        ST_MWALK,
        ST_MLEAP,
        ST_FINISH
    } s2l_state_t;

    // one word per lunar year: bit 16 leap month length, bits 15..4 month
    // lengths (month 1 at bit 15), bits 3..0 leap month number
    localparam logic [WORD_W-1:0] YEAR_ROM [YEAR_ROM_WORDS] = '{
        17'h04bd8, 17'h04ae0, 17'h0a570, 17'h054d5, 17'h0d260, 17'h0d950, 17'h16554,
        17'h056a0, 17'h09ad0, 17'h055d2, 17'h04ae0, 17'h0a5b6, 17'h0a4d0, 17'h0d250,
        17'h1d255, 17'h0b540, 17'h0d6a0, 17'h0ada2, 17'h095b0, 17'h14977, 17'h04970,
        17'h0a4b0, 17'h0b4b5, 17'h06a50, 17'h06d40, 17'h1ab54, 17'h02b60, 17'h09570,
        17'h052f2, 17'h04970, 17'h06566, 17'h0d4a0, 17'h0ea50, 17'h16a95, 17'h05ad0,
        17'h02b60, 17'h186e3, 17'h092e0, 17'h1c8d7, 17'h0c950, 17'h0d4a0, 17'h1d8a6,
        17'h0b550, 17'h056a0, 17'h1a5b4, 17'h025d0, 17'h092d0, 17'h0d2b2, 17'h0a950,
        17'h0b557, 17'h06ca0, 17'h0b550, 17'h15355, 17'h04da0, 17'h0a5b0, 17'h14573,
        17'h052b0, 17'h0a9a8, 17'h0e950, 17'h06aa0, 17'h0aea6, 17'h0ab50, 17'h04b60,
        17'h0aae4, 17'h0a570, 17'h05260, 17'h0f263, 17'h0d950, 17'h05b57, 17'h056a0,
        17'h096d0, 17'h04dd5, 17'h04ad0, 17'h0a4d0, 17'h0d4d4, 17'h0d250, 17'h0d558,
        17'h0b540, 17'h0b6a0, 17'h195a6, 17'h095b0, 17'h049b0, 17'h0a974, 17'h0a4b0,
        17'h0b27a, 17'h06a50, 17'h06d40, 17'h0af46, 17'h0ab60, 17'h09570, 17'h04af5,
        17'h04970, 17'h064b0, 17'h074a3, 17'h0ea50, 17'h06b58, 17'h05ac0, 17'h0ab60,
        17'h096d5, 17'h092e0, 17'h0c960, 17'h0d954, 17'h0d4a0, 17'h0da50, 17'h07552,
        17'h056a0, 17'h0abb7, 17'h025d0, 17'h092d0, 17'h0cab5, 17'h0a950, 17'h0b4a0,
        17'h0baa4, 17'h0ad50, 17'h055d9, 17'h04ba0, 17'h0a5b0, 17'h15176, 17'h052b0,
        17'h0a930, 17'h07954, 17'h06aa0, 17'h0ad50, 17'h05b52, 17'h04b60, 17'h0a6e6,
        17'h0a4e0, 17'h0d260, 17'h0ea65, 17'h0d530, 17'h05aa0, 17'h076a3, 17'h096d0,
        17'h04afb, 17'h04ad0, 17'h0a4d0, 17'h1d0b6, 17'h0d250, 17'h0d520, 17'h0dd45,
        17'h0b5a0, 17'h056d0, 17'h055b2, 17'h049b0, 17'h0a577, 17'h0a4b0, 17'h0aa50,
        17'h1b255, 17'h06d20, 17'h0ada0, 17'h14b63, 17'h09370, 17'h049f8, 17'h04970,
        17'h064b0, 17'h168a6, 17'h0ea50, 17'h06b20, 17'h1a6c4, 17'h0aae0, 17'h092e0,
        17'h0d2e3, 17'h0c960, 17'h0d557, 17'h0d4a0, 17'h0da50, 17'h05d55, 17'h056a0,
        17'h0a6d0, 17'h055d4, 17'h052d0, 17'h0a9b8, 17'h0a950, 17'h0b4a0, 17'h0b6a6,
        17'h0ad50, 17'h055a0, 17'h0aba4, 17'h0a5b0, 17'h052b0, 17'h0b273, 17'h06930,
        17'h07337, 17'h06aa0, 17'h0ad50, 17'h14b55, 17'h04b60, 17'h0a570, 17'h054e4,
        17'h0d160, 17'h0e968, 17'h0d520, 17'h0daa0, 17'h16aa6, 17'h056d0, 17'h04ae0,
        17'h0a9d4, 17'h0a2d0, 17'h0d150, 17'h0f252, 17'h0d520
    };

    // days in the gregorian months before the given one, common year
    function automatic logic [8:0] days_before_month(input logic [3:0] m);
        logic [8:0] d;
        unique case (m)
            4'd1:    d = 9'd0;
            4'd2:    d = 9'd31;
            4'd3:    d = 9'd59;
            4'd4:    d = 9'd90;
            4'd5:    d = 9'd120;
            4'd6:    d = 9'd151;
            4'd7:    d = 9'd181;
            4'd8:    d = 9'd212;
            4'd9:    d = 9'd243;
            4'd10:   d = 9'd273;
            4'd11:   d = 9'd304;
            4'd12:   d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

    // total days of one lunar year from its table word
    function automatic logic [YLEN_W-1:0] lunar_year_len(input logic [WORD_W-1:0] w);
        logic [YLEN_W-1:0] len;
        len = YLEN_W'(YEAR_BASE_LEN);
        for (int k = 4; k < 16; k++) begin
            len = len + YLEN_W'(w[k]);
        end
        if (w[3:0] != 4'd0) begin
            len = len + YLEN_W'(MONTH_BASE) + YLEN_W'(w[16]);
        end
        return len;
    endfunction

endpackage

// ===== src/solar_to_lunar_date.sv =====
// A bad year or month skips both walks and goes straight to the result.
// One transaction at a time: the gregorian year count, then the lunar year walk over the
// table memory (one word read per cycle), then the month walk.
// Reset (rst_n, asynchronous, active low) returns the sequencer to idle and clears
// the result valid flag; payload registers are not reset and there is no clearing pass.
// ----------------------------------------------------------------------------
// solar_to_lunar_date: gregorian date to chinese lunar date converter
// Counts days from the base date, then walks the lunar year table held in a
// synchronous memory, year by year and then month by month.
// ----------------------------------------------------------------------------
module solar_to_lunar_date
    import s2l_pkg::*;
#(
    parameter int LAST_YEAR = LAST_YEAR_MAX
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  s2l_in_t  in_data,
    output logic     out_valid,
    input  logic     out_ready,
    output s2l_out_t out_data
);

    localparam int ROM_DEPTH = LAST_YEAR - BASE_YEAR + 1;
    localparam int IDX_W     = (ROM_DEPTH > 1) ? $clog2(ROM_DEPTH) : 1;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(ROM_DEPTH - 1);

    // table memory
    logic [WORD_W-1:0] rom_mem [ROM_DEPTH];
    logic [WORD_W-1:0] rom_q_reg;
    logic [IDX_W-1:0]  rd_addr;

    for (genvar k = 0; k < ROM_DEPTH; k++) begin : g_rom
        assign rom_mem[k] = YEAR_ROM[k];
    end

    always_ff @(posedge clk) begin
        rom_q_reg <= rom_mem[rd_addr];
    end

    // registers
    s2l_state_t        state_reg, state_next;
    logic [11:0]       sy_reg, sy_next;
    logic [3:0]        sm_reg, sm_next;
    logic [4:0]        sd_reg, sd_next;
    logic [11:0]       gy_reg, gy_next;
    logic [6:0]        c100_reg, c100_next;
    logic [8:0]        c400_reg, c400_next;
    logic [DAYS_W-1:0] days_reg, days_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [3:0]        stem_reg, stem_next;
    logic [3:0]        branch_reg, branch_next;
    logic [WORD_W-1:0] word_reg, word_next;
    logic [3:0]        lm_reg, lm_next;
    logic              lleap_reg, lleap_next;
    logic              ok_reg, ok_next;
    logic              out_valid_reg, out_valid_next;
    s2l_out_t          out_reg, out_next;

    // shared conditions
    logic              in_fire;
    logic              range_ok;
    logic              gy_leap;
    logic              gy_done;
    logic [DAYS_W-1:0] total_days;
    logic              before_base;
    logic [YLEN_W-1:0] ylen;
    logic              year_fits;
    logic [3:0]        msel;
    logic [MLEN_W-1:0] mlen;
    logic [MLEN_W-1:0] llen;
    logic              month_fits;
    logic              leap_fits;
    logic              month_end;
    logic              out_free;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign out_free  = !out_valid_reg || out_ready;

    assign range_ok = (in_data.solar_year >= 12'(BASE_YEAR))
                   && (in_data.solar_year <= 12'(LAST_YEAR))
                   && (in_data.solar_month >= 4'd1)
                   && (in_data.solar_month <= 4'(MONTHS));

    // gregorian leap rule from the running residue counters
    assign gy_leap = ((gy_reg[1:0] == 2'd0) && (c100_reg != 7'd0)) || (c400_reg == 9'd0);
    assign gy_done = (gy_reg == sy_reg);

    // day count up to the requested date, once the whole years are in
    assign total_days = days_reg
                      + DAYS_W'(days_before_month(sm_reg))
                      + DAYS_W'(gy_leap && (sm_reg > 4'd2))
                      + DAYS_W'(sd_reg);
    assign before_base = (total_days < DAYS_W'(BASE_DAY));

    // lunar year length from the word just read
    assign ylen      = lunar_year_len(rom_q_reg);
    assign year_fits = (days_reg < DAYS_W'(ylen));

    // month lengths of the chosen year
    assign msel       = 4'(MONTHS) - lm_reg;
    assign mlen       = MLEN_W'(MONTH_BASE) + MLEN_W'(word_reg[4 + msel]);
    assign llen       = MLEN_W'(MONTH_BASE) + MLEN_W'(word_reg[16]);
    assign month_fits = (days_reg < DAYS_W'(mlen));
    assign leap_fits  = (days_reg < DAYS_W'(llen));
    assign month_end  = (days_reg == '0) || (lm_reg > 4'(MONTHS));

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire) begin
                    state_next = range_ok ? ST_GYEAR : ST_FINISH;
                end
            end
            ST_GYEAR:
            begin
                if (gy_done) begin
                    state_next = before_base ? ST_FINISH : ST_YPRIME;
                end
            end
            ST_YPRIME:
            begin
                state_next = ST_YWALK;
            end
            ST_YWALK:
            begin
                if (year_fits) begin
                    state_next = ST_MWALK;
                end else if (idx_reg == IDX_LAST) begin
                    state_next = ST_FINISH;
                end
            end
            ST_MWALK:
            begin
                if (month_end || month_fits) begin
                    state_next = ST_FINISH;
                end else if (word_reg[3:0] == lm_reg) begin
                    state_next = ST_MLEAP;
                end
            end
            ST_MLEAP:
            begin
                state_next = leap_fits ? ST_FINISH : ST_MWALK;
            end
            ST_FINISH:
            begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and result
    always_comb
    begin
        sy_next        = sy_reg;
        sm_next        = sm_reg;
        sd_next        = sd_reg;
        gy_next        = gy_reg;
        c100_next      = c100_reg;
        c400_next      = c400_reg;
        days_next      = days_reg;
        idx_next       = idx_reg;
        stem_next      = stem_reg;
        branch_next    = branch_reg;
        word_next      = word_reg;
        lm_next        = lm_reg;
        lleap_next     = lleap_reg;
        ok_next        = ok_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        rd_addr        = idx_reg;

        if (out_valid_reg && out_ready) begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire) begin
                    sy_next     = in_data.solar_year;
                    sm_next     = in_data.solar_month;
                    sd_next     = in_data.solar_day;
                    gy_next     = 12'(BASE_YEAR);
                    c100_next   = 7'(C100_START);
                    c400_next   = 9'(C400_START);
                    days_next   = '0;
                    idx_next    = '0;
                    stem_next   = 4'(STEM_START);
                    branch_next = 4'(BRANCH_START);
                    lm_next     = 4'd1;
                    lleap_next  = 1'b0;
                    ok_next     = range_ok;
                end
            end
            ST_GYEAR:
            begin
                // one whole gregorian year per cycle
                if (!gy_done) begin
                    days_next = days_reg + (gy_leap ? DAYS_W'(366) : DAYS_W'(365));
                    gy_next   = gy_reg + 12'd1;
                    c100_next = (c100_reg == 7'd99) ? 7'd0 : c100_reg + 7'd1;
                    c400_next = (c400_reg == 9'd399) ? 9'd0 : c400_reg + 9'd1;
                end else if (before_base) begin
                    ok_next = 1'b0;
                end else begin
                    days_next = total_days - DAYS_W'(BASE_DAY);
                end
            end
            ST_YPRIME:
            begin
                rd_addr = '0;
            end
            ST_YWALK:
            begin
                // peel whole lunar years, next word read ahead
                if (year_fits) begin
                    word_next = rom_q_reg;
                end else if (idx_reg == IDX_LAST) begin
                    ok_next = 1'b0;
                end else begin
                    days_next   = days_reg - DAYS_W'(ylen);
                    idx_next    = idx_reg + IDX_W'(1);
                    rd_addr     = idx_reg + IDX_W'(1);
                    stem_next   = (stem_reg == 4'(STEM_COUNT - 1)) ? 4'd0 : stem_reg + 4'd1;
                    branch_next = (branch_reg == 4'(BRANCH_COUNT - 1)) ? 4'd0
                                                                       : branch_reg + 4'd1;
                end
            end
            ST_MWALK:
            begin
                if (month_end) begin
                    ok_next = (lm_reg <= 4'(MONTHS));
                end else if (!month_fits) begin
                    days_next = days_reg - DAYS_W'(mlen);
                    if (word_reg[3:0] != lm_reg) begin
                        lm_next = lm_reg + 4'd1;
                    end
                end
            end
            ST_MLEAP:
            begin
                if (leap_fits) begin
                    lleap_next = 1'b1;
                end else begin
                    days_next = days_reg - DAYS_W'(llen);
                    lm_next   = lm_reg + 4'd1;
                end
            end
            ST_FINISH:
            begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    if (ok_reg) begin
                        out_next.valid_res     = 1'b1;
                        out_next.lunar_year    = 12'(BASE_YEAR) + 12'(idx_reg);
                        out_next.lun_month     = lm_reg;
                        out_next.lun_day       = 5'(days_reg + DAYS_W'(1));
                        out_next.in_leap_month = lleap_reg;
                        out_next.stem_index    = stem_reg;
                        out_next.branch_index  = branch_reg;
                    end else begin
                        out_next = '0;
                    end
                end
            end
            default:
            begin
                ok_next = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        sy_reg     <= sy_next;
        sm_reg     <= sm_next;
        sd_reg     <= sd_next;
        gy_reg     <= gy_next;
        c100_reg   <= c100_next;
        c400_reg   <= c400_next;
        days_reg   <= days_next;
        idx_reg    <= idx_next;
        stem_reg   <= stem_next;
        branch_reg <= branch_next;
        word_reg   <= word_next;
        lm_reg     <= lm_next;
        lleap_reg  <= lleap_next;
        ok_reg     <= ok_next;
        out_reg    <= out_next;
    end

    // table index never runs past the last year
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_YWALK) |-> (idx_reg <= IDX_LAST))
        else $error("lunar year index beyond table");

    // gregorian year count never overshoots the requested year
    a_gyear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_GYEAR) |-> (gy_reg <= sy_reg))
        else $error("gregorian year count overshoot");

    // leap month step only at the leap month of the year
    a_leap_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MLEAP) |-> (lm_reg == word_reg[3:0]) && (lm_reg != 4'd0))
        else $error("leap month step at wrong month");

    // a converted result always carries a real month and day
    a_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.valid_res) |->
            (out_data.lun_month != 4'd0) && (out_data.lun_month <= 4'(MONTHS))
            && (out_data.lun_day != 5'd0) && (out_data.lun_day <= 5'd30))
        else $error("converted result out of range");

endmodule

// ===== dv/s2l_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// s2l_checker: scoreboard for the solar to lunar date converter
// Watches both channels of the converter, works out the lunar date of every
// accepted input transaction on its own and compares each result transaction
// field by field, in order, with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module s2l_checker
    import s2l_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  logic     in_ready,
    input  s2l_in_t  in_data,
    input  logic     out_valid,
    input  logic     out_ready,
    input  s2l_out_t out_data,
    output int       fail_count,
    output int       pending,
    output int       dates_checked,
    output int       out_of_range,
    output int       leap_hits
);

    localparam int FIRST_YEAR   = BASE_YEAR;
    localparam int FINAL_YEAR   = LAST_YEAR_MAX;
    localparam int START_DAY    = BASE_DAY;
    localparam int PRINT_LIMIT  = 30;
    localparam int SHORT_MONTH  = 29;
    localparam int FIRST_MONTH  = 1;
    localparam int FINAL_MONTH  = 12;

    // gregorian month lengths in a common year
    localparam int GREG_MONTH_DAYS [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

    // lunar year words, 1900 onwards: bit 16 leap month is long, bits 15..4
    // long months (month 1 at bit 15), bits 3..0 leap month number
    localparam int unsigned YEAR_WORDS [201] = '{
        'h04bd8, 'h04ae0, 'h0a570, 'h054d5, 'h0d260, 'h0d950, 'h16554, 'h056a0, 'h09ad0, 'h055d2,
        'h04ae0, 'h0a5b6, 'h0a4d0, 'h0d250, 'h1d255, 'h0b540, 'h0d6a0, 'h0ada2, 'h095b0, 'h14977,
        'h04970, 'h0a4b0, 'h0b4b5, 'h06a50, 'h06d40, 'h1ab54, 'h02b60, 'h09570, 'h052f2, 'h04970,
        'h06566, 'h0d4a0, 'h0ea50, 'h16a95, 'h05ad0, 'h02b60, 'h186e3, 'h092e0, 'h1c8d7, 'h0c950,
        'h0d4a0, 'h1d8a6, 'h0b550, 'h056a0, 'h1a5b4, 'h025d0, 'h092d0, 'h0d2b2, 'h0a950, 'h0b557,
        'h06ca0, 'h0b550, 'h15355, 'h04da0, 'h0a5b0, 'h14573, 'h052b0, 'h0a9a8, 'h0e950, 'h06aa0,
        'h0aea6, 'h0ab50, 'h04b60, 'h0aae4, 'h0a570, 'h05260, 'h0f263, 'h0d950, 'h05b57, 'h056a0,
        'h096d0, 'h04dd5, 'h04ad0, 'h0a4d0, 'h0d4d4, 'h0d250, 'h0d558, 'h0b540, 'h0b6a0, 'h195a6,
        'h095b0, 'h049b0, 'h0a974, 'h0a4b0, 'h0b27a, 'h06a50, 'h06d40, 'h0af46, 'h0ab60, 'h09570,
        'h04af5, 'h04970, 'h064b0, 'h074a3, 'h0ea50, 'h06b58, 'h05ac0, 'h0ab60, 'h096d5, 'h092e0,
        'h0c960, 'h0d954, 'h0d4a0, 'h0da50, 'h07552, 'h056a0, 'h0abb7, 'h025d0, 'h092d0, 'h0cab5,
        'h0a950, 'h0b4a0, 'h0baa4, 'h0ad50, 'h055d9, 'h04ba0, 'h0a5b0, 'h15176, 'h052b0, 'h0a930,
        'h07954, 'h06aa0, 'h0ad50, 'h05b52, 'h04b60, 'h0a6e6, 'h0a4e0, 'h0d260, 'h0ea65, 'h0d530,
        'h05aa0, 'h076a3, 'h096d0, 'h04afb, 'h04ad0, 'h0a4d0, 'h1d0b6, 'h0d250, 'h0d520, 'h0dd45,
        'h0b5a0, 'h056d0, 'h055b2, 'h049b0, 'h0a577, 'h0a4b0, 'h0aa50, 'h1b255, 'h06d20, 'h0ada0,
        'h14b63, 'h09370, 'h049f8, 'h04970, 'h064b0, 'h168a6, 'h0ea50, 'h06b20, 'h1a6c4, 'h0aae0,
        'h092e0, 'h0d2e3, 'h0c960, 'h0d557, 'h0d4a0, 'h0da50, 'h05d55, 'h056a0, 'h0a6d0, 'h055d4,
        'h052d0, 'h0a9b8, 'h0a950, 'h0b4a0, 'h0b6a6, 'h0ad50, 'h055a0, 'h0aba4, 'h0a5b0, 'h052b0,
        'h0b273, 'h06930, 'h07337, 'h06aa0, 'h0ad50, 'h14b55, 'h04b60, 'h0a570, 'h054e4, 'h0d160,
        'h0e968, 'h0d520, 'h0daa0, 'h16aa6, 'h056d0, 'h04ae0, 'h0a9d4, 'h0a2d0, 'h0d150, 'h0f252,
        'h0d520
    };

    // one accepted date and the lunar date it should give
    typedef struct {
        s2l_in_t  src;
        s2l_out_t res;
    } lunar_pair_t;

    lunar_pair_t lunar_due_q [$];

    function automatic bit is_greg_leap(input int unsigned y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    // 30 or 29 days, month 1 at bit 15
    function automatic int unsigned lunar_mon_days(input logic [16:0] w, input int unsigned m);
        return w[16 - m] ? 30 : SHORT_MONTH;
    endfunction

    function automatic int unsigned lunar_year_days(input logic [16:0] w);
        int unsigned sum;
        sum = 0;
        for (int m = FIRST_MONTH; m <= FINAL_MONTH; m++)
            sum += lunar_mon_days(w, m);
        if (w[3:0] != 4'd0)
            sum += w[16] ? 30 : SHORT_MONTH;
        return sum;
    endfunction

    // gregorian date to lunar date, all zero when the date cannot be converted
    function automatic s2l_out_t lunar_date_of(input s2l_in_t d);
        s2l_out_t    r;
        int unsigned sy, sm, days, off, ly, len, lm, leapm;
        logic [16:0] w;
        bit          in_leap, found;
        r  = '0;
        sy = d.solar_year;
        sm = d.solar_month;
        if (sy < FIRST_YEAR || sy > FINAL_YEAR || sm < FIRST_MONTH || sm > FINAL_MONTH)
            return r;

        // days since 1900-01-00
        days = 0;
        for (int unsigned y = FIRST_YEAR; y < sy; y++)
            days += is_greg_leap(y) ? 366 : 365;
        for (int unsigned m = FIRST_MONTH; m < sm; m++)
            days += (m == 2 && is_greg_leap(sy)) ? 29 : GREG_MONTH_DAYS[m - 1];
        days += d.solar_day;
        if (days < START_DAY)
            return r;
        off = days - START_DAY;

        // peel off whole lunar years
        ly    = FIRST_YEAR;
        found = 1'b0;
        while (!found) begin
            if (ly > FINAL_YEAR)
                return r;
            len = lunar_year_days(YEAR_WORDS[ly - FIRST_YEAR][16:0]);
            if (off < len)
                found = 1'b1;
            else begin
                off -= len;
                ly++;
            end
        end

        // then months, the leap month straight after its namesake
        w       = YEAR_WORDS[ly - FIRST_YEAR][16:0];
        leapm   = w[3:0];
        lm      = FIRST_MONTH;
        in_leap = 1'b0;
        found   = 1'b0;
        while (!found && off > 0 && lm <= FINAL_MONTH) begin
            len = lunar_mon_days(w, lm);
            if (off < len)
                found = 1'b1;
            else begin
                off -= len;
                if (leapm == lm) begin
                    len = w[16] ? 30 : SHORT_MONTH;
                    if (off < len) begin
                        in_leap = 1'b1;
                        found   = 1'b1;
                    end
                    else
                        off -= len;
                end
                if (!found)
                    lm++;
            end
        end
        if (lm > FINAL_MONTH)
            return r;

        r.valid_res     = 1'b1;
        r.lunar_year    = 12'(ly);
        r.lun_month     = 4'(lm);
        r.lun_day       = 5'(off + 1);
        r.in_leap_month = in_leap;
        r.stem_index    = 4'((ly - 4) % 10);
        r.branch_index  = 4'((ly - 4) % 12);
        return r;
    endfunction

    task automatic report(input string msg);
        fail_count++;
        if (fail_count <= PRINT_LIMIT)
            $display("[%0t] ERROR: %s", $realtime, msg);
    endtask

    task automatic check_field(input string name, input int got, input int want,
                               input s2l_in_t src);
        if (got != want)
            report($sformatf("%s wrong for %0d-%0d-%0d: got %0d, expected %0d", name,
                             src.solar_year, src.solar_month, src.solar_day, got, want));
    endtask

    // predict on input transactions, compare on result transactions
    always @(posedge clk) begin
        lunar_pair_t due;
        if (rst_n) begin
            if (in_valid && in_ready)
                lunar_due_q.push_back('{src: in_data, res: lunar_date_of(in_data)});
            if (out_valid && out_ready) begin
                if (lunar_due_q.size() == 0)
                    report($sformatf("result transaction with nothing outstanding: %h",
                                     out_data));
                else begin
                    due = lunar_due_q.pop_front();
                    dates_checked++;
                    if (!due.res.valid_res)
                        out_of_range++;
                    if (due.res.in_leap_month)
                        leap_hits++;
                    check_field("valid_res", out_data.valid_res, due.res.valid_res, due.src);
                    check_field("lunar_year", out_data.lunar_year, due.res.lunar_year, due.src);
                    check_field("lun_month", out_data.lun_month, due.res.lun_month, due.src);
                    check_field("lun_day", out_data.lun_day, due.res.lun_day, due.src);
                    check_field("in_leap_month", out_data.in_leap_month,
                                due.res.in_leap_month, due.src);
                    check_field("stem_index", out_data.stem_index, due.res.stem_index, due.src);
                    check_field("branch_index", out_data.branch_index, due.res.branch_index,
                                due.src);
                end
            end
        end
        pending = lunar_due_q.size();
    end

endmodule

// ===== dv/tb_solar_to_lunar_date.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_solar_to_lunar_date: regression bench for the date converter
// Sends a directed set of boundary dates, then random dates, with random
// gaps on the input side and random back-pressure on the result side; the
// checker beside the converter predicts and compares every transaction.
// ----------------------------------------------------------------------------
module tb_solar_to_lunar_date;
    import s2l_pkg::*;

    localparam int HALF_PERIOD  = 5;
    localparam int RESET_CYCLES = 7;
    localparam int RANDOM_ITEMS = 750;
    localparam int DRAIN_CYCLES = 500;
    localparam int CYCLE_LIMIT  = 2_000_000;

    logic     clk       = 1'b0;
    logic     rst_n     = 1'b0;
    logic     in_valid  = 1'b0;
    logic     in_ready;
    s2l_in_t  in_data   = '0;
    logic     out_valid;
    logic     out_ready = 1'b0;
    s2l_out_t out_data;

    int fail_count;
    int pending;
    int dates_checked;
    int out_of_range;
    int leap_hits;
    int cycles    = 0;
    bit send_calm = 1'b0;

    always #HALF_PERIOD clk = ~clk;

    solar_to_lunar_date dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    s2l_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .in_data       (in_data),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_data      (out_data),
        .fail_count    (fail_count),
        .pending       (pending),
        .dates_checked (dates_checked),
        .out_of_range  (out_of_range),
        .leap_hits     (leap_hits)
    );

    // mostly short gaps, now and then a long one, none in calm stretches
    function automatic int idle_gap(input bit calm);
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 15);
        return $urandom_range(20, 80);
    endfunction

    // one input transaction; valid stays up when no gap follows
    task automatic send_date(input int y, input int m, input int d);
        int gap;
        gap = idle_gap(send_calm);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= s2l_in_t'{solar_year: 12'(y), solar_month: 4'(m), solar_day: 5'(d)};
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // run watchdog
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // result side back-pressure
    initial begin
        bit calm;
        int n;
        wait (rst_n);
        @(posedge clk);
        forever begin
            calm = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(20, 200)) begin
                n = idle_gap(calm);
                repeat (n) begin
                    out_ready <= 1'b0;
                    @(posedge clk);
                end
                out_ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // stimulus and verdict
    initial begin
        int pick;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // first day of the table, the days just before it, and day zero of the month after
        send_date(1900, 1, 31);
        send_date(1900, 1, 30);
        send_date(1900, 1, 0);
        send_date(1900, 2, 0);
        // years and months outside the table
        send_date(1899, 12, 31);
        send_date(2101, 1, 1);
        send_date(0, 0, 0);
        send_date(4095, 15, 31);
        send_date(2000, 0, 15);
        send_date(2000, 13, 1);
        send_date(2000, 15, 1);
        // last year of the table
        send_date(2100, 1, 1);
        send_date(2100, 12, 31);
        // leap months, short and long
        send_date(2020, 5, 23);
        send_date(2020, 6, 20);
        send_date(2023, 3, 22);
        send_date(1906, 6, 1);
        send_date(2033, 12, 22);
        // new year and its eve, day numbers past the month end
        send_date(2024, 2, 10);
        send_date(2024, 2, 9);
        send_date(2000, 2, 31);
        send_date(1904, 2, 29);
        send_date(1984, 2, 2);

        // random dates, mostly inside the table
        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            if (k % 50 == 0)
                send_calm = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 99);
            if (pick < 10)
                send_date($urandom_range(0, 4095), $urandom_range(0, 15), $urandom_range(0, 31));
            else if (pick < 16)
                send_date(1900, $urandom_range(1, 2), $urandom_range(0, 31));
            else if (pick < 22)
                send_date($urandom_range(2095, 2100), $urandom_range(1, 12),
                          $urandom_range(0, 31));
            else
                send_date($urandom_range(1900, 2100), $urandom_range(1, 12),
                          $urandom_range(0, 31));
        end
        in_valid <= 1'b0;
        @(posedge clk);

        // drain outstanding results, then watch for strays
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d dates converted and checked: %0d outside the table, %0d in a leap month",
                 dates_checked, out_of_range, leap_hits);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
